### design/ors_pkg.sv
// Shared codes and types for the 1-Wire ROM search controller.
// No dependencies; imported by ors_dir, one_wire_rom_search and the bench.
`default_nettype none
package ors_pkg;

  localparam int CODE_BITS_DEF   = 64;
  localparam int FAMILY_BITS_DEF = 8;
  localparam int FN_W            = 2;
  localparam int ACT_W           = 2;
  localparam int FAM_OUT_W       = 4;
  localparam int LOW_BYTE_W      = 8;

  localparam logic [FN_W-1:0] FN_START     = 2'd0;
  localparam logic [FN_W-1:0] FN_RESET_ANS = 2'd1;
  localparam logic [FN_W-1:0] FN_BIT_PAIR  = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESET  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd3;

  typedef struct packed {
    logic dir;
    logic zero_taken;
  } dir_t;

endpackage
`default_nettype wire

### design/ors_dir.sv
// Direction decision for one bit pair of the ROM search.
// Depends on ors_pkg (dir_t).
`default_nettype none
module ors_dir #(
  parameter int POS_W = 7
) (
  input  wire logic [POS_W-1:0] pos,
  input  wire logic [POS_W-1:0] last_branch,
  input  wire logic             stored_bit,
  input  wire logic             id_bit,
  input  wire logic             cmp_id_bit,
  output ors_pkg::dir_t         pick
);
  import ors_pkg::*;

  logic conflict_dir;

  always_comb begin
    if (pos < last_branch) begin
      conflict_dir = stored_bit;
    end else begin
      conflict_dir = (pos == last_branch);
    end
    if (id_bit != cmp_id_bit) begin
      pick.dir        = id_bit;
      pick.zero_taken = 1'b0;
    end else begin
      pick.dir        = conflict_dir;
      pick.zero_taken = !conflict_dir;
    end
  end

endmodule
`default_nettype wire

### design/one_wire_rom_search.sv
// 1-Wire ROM search controller: search state, per-item decision, result queue.
// Depends on ors_pkg and ors_dir.
//
//  channel   valid         stall         payload
//  item      item_valid    item_stall    func restart presence id_bit cmp_id_bit
//  result    result_valid  result_stall  action write_bit round_done found
//                                        rom_code last_device family_discrepancy
//
// One item per cycle while item_stall is low; its result is registered into the result queue.
// A two-entry result queue takes an item while a result waits; item_stall is high
// only when both entries are held.
// Synchronous reset clears the search history, the phase and the queue.
`default_nettype none
module one_wire_rom_search #(
  parameter int CODE_BITS   = ors_pkg::CODE_BITS_DEF,
  parameter int FAMILY_BITS = ors_pkg::FAMILY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic [ors_pkg::FN_W-1:0]       func,
  input  wire logic                           restart,
  input  wire logic                           presence,
  input  wire logic                           id_bit,
  input  wire logic                           cmp_id_bit,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [ors_pkg::ACT_W-1:0]           action,
  output logic                                write_bit,
  output logic                                round_done,
  output logic                                found,
  output logic [CODE_BITS-1:0]                rom_code,
  output logic                                last_device,
  output logic [ors_pkg::FAM_OUT_W-1:0]       family_discrepancy
);
  import ors_pkg::*;

  localparam int POS_W = $clog2(CODE_BITS + 2);
  localparam int IDX_W = $clog2(CODE_BITS);
  localparam int FAM_W = $clog2(FAMILY_BITS + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RESET,
    PH_BITS
  } phase_t;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic                 write_bit;
    logic                 round_done;
    logic                 found;
    logic                 last_device;
    logic [FAM_OUT_W-1:0] family_discrepancy;
  } res_t;

  phase_t               phase, phase_next;
  logic [CODE_BITS-1:0] rom_store, rom_store_next;
  logic [POS_W-1:0]     last_branch, last_branch_next;
  logic [FAM_W-1:0]     family_mark, family_mark_next;
  logic                 done_flag, done_flag_next;
  logic [POS_W-1:0]     bit_position, bit_position_next;
  logic [POS_W-1:0]     round_last_zero, round_last_zero_next;

  res_t                 res_next;
  logic [CODE_BITS-1:0] code_next;

  res_t                 q_res  [2];
  logic [CODE_BITS-1:0] q_code [2];
  logic                 wr_ptr, rd_ptr;
  logic [1:0]           count;

  logic                 accept, pop;
  logic [IDX_W-1:0]     idx;
  dir_t                 pick;

  assign accept       = item_valid && !item_stall;
  assign pop          = result_valid && !result_stall;
  assign item_stall   = (count == 2'd2);
  assign result_valid = (count != 2'd0);
  assign idx          = IDX_W'(bit_position - POS_W'(1));

  ors_dir #(.POS_W(POS_W)) u_dir (
    .pos         (bit_position),
    .last_branch (last_branch),
    .stored_bit  (rom_store[idx]),
    .id_bit      (id_bit),
    .cmp_id_bit  (cmp_id_bit),
    .pick        (pick)
  );

  always_comb begin
    phase_next           = phase;
    rom_store_next       = rom_store;
    last_branch_next     = last_branch;
    family_mark_next     = family_mark;
    done_flag_next       = done_flag;
    bit_position_next    = bit_position;
    round_last_zero_next = round_last_zero;
    res_next             = '0;
    code_next            = '0;
    case (func)
      FN_START: begin
        bit_position_next    = POS_W'(1);
        round_last_zero_next = '0;
        if (restart) begin
          last_branch_next = '0;
          family_mark_next = '0;
          done_flag_next   = 1'b0;
        end
        if (done_flag && !restart) begin
          last_branch_next    = '0;
          family_mark_next    = '0;
          done_flag_next      = 1'b0;
          res_next.round_done = 1'b1;
          phase_next          = PH_IDLE;
        end else begin
          res_next.action = ACT_RESET;
          phase_next      = PH_RESET;
        end
      end
      FN_RESET_ANS: begin
        if (phase == PH_RESET) begin
          if (presence) begin
            res_next.action      = ACT_SEARCH;
            bit_position_next    = POS_W'(1);
            round_last_zero_next = '0;
            phase_next           = PH_BITS;
          end else begin
            last_branch_next    = '0;
            family_mark_next    = '0;
            done_flag_next      = 1'b0;
            res_next.round_done = 1'b1;
            phase_next          = PH_IDLE;
          end
        end
      end
      FN_BIT_PAIR: begin
        if (phase == PH_BITS) begin
          if (id_bit && cmp_id_bit) begin
            last_branch_next    = '0;
            family_mark_next    = '0;
            done_flag_next      = 1'b0;
            res_next.round_done = 1'b1;
            phase_next          = PH_IDLE;
          end else begin
            if (pick.zero_taken) begin
              round_last_zero_next = bit_position;
              if (32'(bit_position) <= FAMILY_BITS) begin
                family_mark_next = FAM_W'(bit_position);
              end
            end
            rom_store_next[idx] = pick.dir;
            res_next.action     = ACT_WRITE;
            res_next.write_bit  = pick.dir;
            bit_position_next   = bit_position + POS_W'(1);
            if (bit_position >= POS_W'(CODE_BITS)) begin
              res_next.round_done = 1'b1;
              phase_next          = PH_IDLE;
              last_branch_next    = round_last_zero_next;
              done_flag_next      = (round_last_zero_next == '0);
              if (rom_store_next[LOW_BYTE_W-1:0] == '0) begin
                last_branch_next = '0;
                family_mark_next = '0;
                done_flag_next   = 1'b0;
              end else begin
                res_next.found              = 1'b1;
                code_next                   = rom_store_next;
                res_next.last_device        = done_flag_next;
                res_next.family_discrepancy = FAM_OUT_W'(family_mark_next);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      rom_store       <= '0;
      last_branch     <= '0;
      family_mark     <= '0;
      done_flag       <= 1'b0;
      bit_position    <= POS_W'(1);
      round_last_zero <= '0;
      wr_ptr          <= 1'b0;
      rd_ptr          <= 1'b0;
      count           <= 2'd0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        rom_store       <= rom_store_next;
        last_branch     <= last_branch_next;
        family_mark     <= family_mark_next;
        done_flag       <= done_flag_next;
        bit_position    <= bit_position_next;
        round_last_zero <= round_last_zero_next;
        q_res[wr_ptr]   <= res_next;
        q_code[wr_ptr]  <= code_next;
        wr_ptr          <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({accept, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign action             = q_res[rd_ptr].action;
  assign write_bit          = q_res[rd_ptr].write_bit;
  assign round_done         = q_res[rd_ptr].round_done;
  assign found              = q_res[rd_ptr].found;
  assign last_device        = q_res[rd_ptr].last_device;
  assign family_discrepancy = q_res[rd_ptr].family_discrepancy;
  assign rom_code           = q_code[rd_ptr];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result queue count out of range");
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> round_done && rom_code[LOW_BYTE_W-1:0] != '0)
    else $error("found result without round end or with zero family byte");
  a_last_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_device |-> found)
    else $error("last device flagged on a failed round");
  a_wbit_action: assert property (@(posedge clk) disable iff (rst)
    result_valid && write_bit |-> action == ACT_WRITE)
    else $error("write bit set without a write action");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    accept && res_next.round_done |=> phase == PH_IDLE)
    else $error("round ended but phase not idle");
`endif

endmodule
`default_nettype wire

### bench/one_wire_rom_search_tb.sv
// Self-checking bench for one_wire_rom_search: a simulated device population answers
// search rounds, and a scoreboard class predicts and checks every result item.
// Depends on ors_pkg and the one_wire_rom_search RTL.
`default_nettype none
module one_wire_rom_search_tb;
  import ors_pkg::*;

  localparam logic [FN_W-1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 425;
  localparam int MAX_DEVICES = 6;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_AWAIT_PRESENCE,
    PH_READ_BITS
  } search_phase_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic                     write_bit;
    logic                     round_done;
    logic                     found;
    logic [CODE_BITS_DEF-1:0] rom_code;
    logic                     last_device;
    logic [FAM_OUT_W-1:0]     family_discrepancy;
  } search_result_t;

  class rom_search_tracker;
    logic [CODE_BITS_DEF-1:0] code_reg;
    logic [6:0]               last_branch;
    logic [FAM_OUT_W-1:0]     family_mark;
    logic                     done_flag;
    logic [6:0]               bit_pos;
    logic [6:0]               round_zero;
    search_phase_t            phase;
    search_result_t           pending_results[$];
    int                       errors;

    function new();
      code_reg = '0;
      last_branch = '0;
      family_mark = '0;
      done_flag = 1'b0;
      bit_pos = 7'd1;
      round_zero = '0;
      phase = PH_IDLE;
      errors = 0;
    endfunction

    function void forget_branches();
      last_branch = '0;
      family_mark = '0;
      done_flag = 1'b0;
    endfunction

    function search_result_t predict_item(logic [FN_W-1:0] fn, logic rs, logic pr,
                                          logic idb, logic cmpb);
      search_result_t r;
      logic [6:0] pos;
      logic [6:0] pos_m1;
      logic dir;
      r = '0;
      if (fn == FN_START) begin
        if (rs) forget_branches();
        bit_pos = 7'd1;
        round_zero = '0;
        if (done_flag) begin
          forget_branches();
          r.round_done = 1'b1;
          phase = PH_IDLE;
        end else begin
          r.action = ACT_RESET;
          phase = PH_AWAIT_PRESENCE;
        end
      end else if (fn == FN_RESET_ANS && phase == PH_AWAIT_PRESENCE) begin
        if (pr) begin
          r.action = ACT_SEARCH;
          bit_pos = 7'd1;
          round_zero = '0;
          phase = PH_READ_BITS;
        end else begin
          forget_branches();
          r.round_done = 1'b1;
          phase = PH_IDLE;
        end
      end else if (fn == FN_BIT_PAIR && phase == PH_READ_BITS) begin
        if (idb && cmpb) begin
          forget_branches();
          r.round_done = 1'b1;
          phase = PH_IDLE;
        end else begin
          pos = bit_pos;
          pos_m1 = pos - 7'd1;
          if (idb != cmpb) begin
            dir = idb;
          end else begin
            if (pos < last_branch) dir = code_reg[pos_m1[5:0]];
            else dir = (pos == last_branch);
            if (!dir) begin
              round_zero = pos;
              if (pos < FAMILY_BITS_DEF + 1) family_mark = pos[FAM_OUT_W-1:0];
            end
          end
          code_reg[pos_m1[5:0]] = dir;
          r.action = ACT_WRITE;
          r.write_bit = dir;
          bit_pos = pos + 7'd1;
          if (pos >= CODE_BITS_DEF) begin
            r.round_done = 1'b1;
            phase = PH_IDLE;
            last_branch = round_zero;
            done_flag = (last_branch == 0);
            if (code_reg[LOW_BYTE_W-1:0] == 0) begin
              forget_branches();
            end else begin
              r.found = 1'b1;
              r.rom_code = code_reg;
              r.last_device = done_flag;
              r.family_discrepancy = family_mark;
            end
          end
        end
      end
      pending_results.push_back(r);
      return r;
    endfunction

    function void check_result(search_result_t got);
      search_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.action !== want.action) begin
        $display("%0t: action expected %h actual %h", $time, want.action, got.action);
        errors++;
      end
      if (got.write_bit !== want.write_bit) begin
        $display("%0t: write_bit expected %h actual %h", $time, want.write_bit,
                 got.write_bit);
        errors++;
      end
      if (got.round_done !== want.round_done) begin
        $display("%0t: round_done expected %h actual %h", $time, want.round_done,
                 got.round_done);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found expected %h actual %h", $time, want.found, got.found);
        errors++;
      end
      if (got.rom_code !== want.rom_code) begin
        $display("%0t: rom_code expected %h actual %h", $time, want.rom_code, got.rom_code);
        errors++;
      end
      if (got.last_device !== want.last_device) begin
        $display("%0t: last_device expected %h actual %h", $time, want.last_device,
                 got.last_device);
        errors++;
      end
      if (got.family_discrepancy !== want.family_discrepancy) begin
        $display("%0t: family_discrepancy expected %h actual %h", $time,
                 want.family_discrepancy, got.family_discrepancy);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic [FN_W-1:0]          func = FN_START;
  logic                     restart = 1'b0;
  logic                     presence = 1'b0;
  logic                     id_bit = 1'b0;
  logic                     cmp_id_bit = 1'b0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [ACT_W-1:0]         action;
  logic                     write_bit;
  logic                     round_done;
  logic                     found;
  logic [CODE_BITS_DEF-1:0] rom_code;
  logic                     last_device;
  logic [FAM_OUT_W-1:0]     family_discrepancy;

  rom_search_tracker tracker = new();
  int send_idle = 0;
  int recv_stall = 0;
  int items_sent = 0;
  int cycles = 0;
  logic [CODE_BITS_DEF-1:0] devices[$];

  one_wire_rom_search u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .func(func), .restart(restart), .presence(presence),
    .id_bit(id_bit), .cmp_id_bit(cmp_id_bit),
    .result_valid(result_valid), .result_stall(result_stall),
    .action(action), .write_bit(write_bit), .round_done(round_done), .found(found),
    .rom_code(rom_code), .last_device(last_device),
    .family_discrepancy(family_discrepancy)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.check_result({action, write_bit, round_done, found, rom_code, last_device,
                            family_discrepancy});
  end

  task automatic send_item(input logic [FN_W-1:0] fn, input logic rs, input logic pr,
                           input logic idb, input logic cmpb, output search_result_t exp);
    while ($urandom_range(0, 99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    func <= fn;
    restart <= rs;
    presence <= pr;
    id_bit <= idb;
    cmp_id_bit <= cmpb;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    exp = tracker.predict_item(fn, rs, pr, idb, cmpb);
    items_sent++;
  endtask

  task automatic send_noise();
    search_result_t r;
    send_item(FN_W'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), r);
  endtask

  task automatic new_population(input bit zero_family);
    logic [CODE_BITS_DEF-1:0] base;
    logic [CODE_BITS_DEF-1:0] dev;
    int n;
    devices.delete();
    base = {$urandom, $urandom};
    n = $urandom_range(1, MAX_DEVICES);
    for (int d = 0; d < n; d++) begin
      case ($urandom_range(0, 2))
        0: dev = {$urandom, $urandom};
        1: dev = base ^ (64'd1 << $urandom_range(0, 63)) ^ (64'd1 << $urandom_range(0, 63));
        default: dev = {base[CODE_BITS_DEF-1:LOW_BYTE_W], LOW_BYTE_W'($urandom)};
      endcase
      if (zero_family || $urandom_range(0, 19) == 0) dev[LOW_BYTE_W-1:0] = '0;
      devices.push_back(dev);
    end
  endtask

  // One search round against the device population; the bus ANDs all devices
  // still on the selected path.
  task automatic run_round(input logic rs);
    search_result_t r;
    logic [MAX_DEVICES-1:0] on_path;
    logic tb, cb;
    logic pr;
    send_item(FN_START, rs, 1'($urandom), 1'($urandom), 1'($urandom), r);
    if (r.action != ACT_RESET) return;
    if ($urandom_range(0, 15) == 0) send_noise();
    pr = ($urandom_range(0, 15) != 0);
    send_item(FN_RESET_ANS, 1'($urandom), pr, 1'($urandom), 1'($urandom), r);
    if (r.action != ACT_SEARCH) return;
    on_path = '1;
    for (int k = 0; k < CODE_BITS_DEF; k++) begin
      if ($urandom_range(0, 399) == 0) return;
      if ($urandom_range(0, 199) == 0) send_noise();
      tb = 1'b1;
      cb = 1'b1;
      for (int d = 0; d < devices.size(); d++) begin
        if (on_path[d]) begin
          tb &= devices[d][k];
          cb &= ~devices[d][k];
        end
      end
      if ($urandom_range(0, 299) == 0) tb = ~tb;
      if ($urandom_range(0, 299) == 0) cb = ~cb;
      send_item(FN_BIT_PAIR, 1'($urandom), 1'($urandom), tb, cb, r);
      if (r.action != ACT_WRITE || r.round_done) return;
      for (int d = 0; d < devices.size(); d++)
        if (devices[d][k] != r.write_bit) on_path[d] = 1'b0;
    end
  endtask

  initial begin
    search_result_t r;
    int rounds;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 84; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 84; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      if (ph == 0) begin
        // wrong-phase items, presence failure, restart mid-round, each bit-pair kind
        send_item(FN_BIT_PAIR, 1'b0, 1'b0, 1'b1, 1'b0, r);
        send_item(FN_RESET_ANS, 1'b0, 1'b1, 1'b0, 1'b0, r);
        send_item(FN_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, r);
        send_item(FN_START, 1'b1, 1'b0, 1'b0, 1'b0, r);
        send_item(FN_RESET_ANS, 1'b1, 1'b0, 1'b1, 1'b1, r);
        send_item(FN_START, 1'b0, 1'b1, 1'b1, 1'b1, r);
        send_item(FN_START, 1'b0, 1'b0, 1'b0, 1'b0, r);
        send_item(FN_RESET_ANS, 1'b0, 1'b1, 1'b0, 1'b0, r);
        send_item(FN_UNUSED, 1'b0, 1'b0, 1'b0, 1'b0, r);
        send_item(FN_RESET_ANS, 1'b0, 1'b1, 1'b0, 1'b0, r);
        send_item(FN_BIT_PAIR, 1'b0, 1'b0, 1'b0, 1'b1, r);
        send_item(FN_BIT_PAIR, 1'b1, 1'b1, 1'b1, 1'b0, r);
        send_item(FN_BIT_PAIR, 1'b0, 1'b0, 1'b0, 1'b0, r);
        send_item(FN_START, 1'b0, 1'b0, 1'b0, 1'b0, r);
        send_item(FN_BIT_PAIR, 1'b0, 1'b0, 1'b0, 1'b0, r);
        send_item(FN_RESET_ANS, 1'b0, 1'b1, 1'b0, 1'b0, r);
        send_item(FN_BIT_PAIR, 1'b0, 1'b0, 1'b1, 1'b1, r);
        send_item(FN_BIT_PAIR, 1'b0, 1'b0, 1'b1, 1'b0, r);
        new_population(1'b1);
      end else begin
        new_population(1'b0);
      end
      rounds = 0;
      while (items_sent < (ph + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        run_round(rounds == 0 || $urandom_range(0, 9) == 0);
        rounds++;
        if ($urandom_range(0, 5) == 0) new_population(1'b0);
      end
      item_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
design/ors_pkg.sv
design/ors_dir.sv
design/one_wire_rom_search.sv
bench/one_wire_rom_search_tb.sv
